@@ src/bgfd_pkg.sv @@
// shared types, codes and constants of the binary frame deframer
package bgfd_pkg;

   // sync pair of a frame
   localparam logic [7:0] SYNC_A = 8'hB5;
   localparam logic [7:0] SYNC_B = 8'h62;

   // largest payload length the datapath handles
   localparam logic [15:0] PAYLOAD_LIMIT = 16'd1023;

   // reset value of the length limit register
   localparam logic [9:0] MAX_LEN_RESET = 10'd1023;

   // parser phases
   localparam logic [3:0] PH_HUNT    = 4'd0;
   localparam logic [3:0] PH_SYNC2   = 4'd1;
   localparam logic [3:0] PH_CLASS   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CK_A    = 4'd7;
   localparam logic [3:0] PH_CK_B    = 4'd8;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_CKSUM   = 2'd2;
   localparam logic [1:0] KIND_LENGTH  = 2'd3;

   // navigation class and recognized ids
   localparam logic [7:0] CLASS_NAV   = 8'h01;
   localparam logic [7:0] ID_SOL      = 8'h06;
   localparam logic [7:0] ID_POSLLH   = 8'h02;
   localparam logic [7:0] ID_VELNED   = 8'h12;
   localparam logic [7:0] ID_DOP      = 8'h04;
   localparam logic [7:0] ID_STATUS   = 8'h03;

   // message type codes
   localparam logic [2:0] MT_NONE     = 3'd0;
   localparam logic [2:0] MT_SOL      = 3'd1;
   localparam logic [2:0] MT_POSLLH   = 3'd2;
   localparam logic [2:0] MT_VELNED   = 3'd3;
   localparam logic [2:0] MT_DOP      = 3'd4;
   localparam logic [2:0] MT_STATUS   = 3'd5;

   typedef struct packed {
      logic        valid;
      logic [1:0]  result_kind;
      logic [7:0]  payload_byte;
      logic [9:0]  byte_index;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] declared_length;
      logic [2:0]  message_type;
   } bgfd_result_type;

   function automatic logic [2:0] type_code(input logic [7:0] cls, input logic [7:0] id);
      logic [2:0] code;
      code = MT_NONE;
      if (cls == CLASS_NAV) begin
         unique case (id)
            ID_SOL:    code = MT_SOL;
            ID_POSLLH: code = MT_POSLLH;
            ID_VELNED: code = MT_VELNED;
            ID_DOP:    code = MT_DOP;
            ID_STATUS: code = MT_STATUS;
            default:   code = MT_NONE;
         endcase
      end
      return code;
   endfunction

endpackage

@@ src/bgfd_parser.sv @@
// frame parser state, checksum sums and per-byte result decode
module bgfd_parser #(
   parameter logic [15:0] PAYLOAD_LIMIT = bgfd_pkg::PAYLOAD_LIMIT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 rx_byte,
   input  logic [9:0]                 max_len,
   output bgfd_pkg::bgfd_result_type  res
);

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [9:0]  count_ff, count_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;

   logic [7:0]  sum_a_add;
   logic [7:0]  sum_b_add;
   logic [15:0] limit;
   logic [15:0] max_len_wide;
   logic [9:0]  count_inc;

   assign sum_a_add    = sum_a_ff + rx_byte;
   assign sum_b_add    = sum_b_ff + sum_a_add;
   assign max_len_wide = {6'd0, max_len};
   assign limit        = (PAYLOAD_LIMIT < max_len_wide) ? PAYLOAD_LIMIT : max_len_wide;
   assign count_inc    = count_ff + 10'd1;

   always_comb begin
      phase_in  = phase_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      res       = '0;

      unique case (phase_ff)
         bgfd_pkg::PH_SYNC2: begin
            phase_in = (rx_byte == bgfd_pkg::SYNC_B) ? bgfd_pkg::PH_CLASS : bgfd_pkg::PH_HUNT;
         end
         bgfd_pkg::PH_CLASS: begin
            class_in = rx_byte;
            sum_a_in = rx_byte;
            sum_b_in = rx_byte;
            phase_in = bgfd_pkg::PH_ID;
         end
         bgfd_pkg::PH_ID: begin
            id_in    = rx_byte;
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            phase_in = bgfd_pkg::PH_LEN_LO;
         end
         bgfd_pkg::PH_LEN_LO: begin
            length_in = {8'd0, rx_byte};
            sum_a_in  = sum_a_add;
            sum_b_in  = sum_b_add;
            phase_in  = bgfd_pkg::PH_LEN_HI;
         end
         bgfd_pkg::PH_LEN_HI: begin
            length_in = {rx_byte, length_ff[7:0]};
            sum_a_in  = sum_a_add;
            sum_b_in  = sum_b_add;
            count_in  = '0;
            if (length_in > limit) begin
               phase_in        = bgfd_pkg::PH_HUNT;
               res.valid       = 1'b1;
               res.result_kind = bgfd_pkg::KIND_LENGTH;
            end else if (length_in == 16'd0) begin
               phase_in = bgfd_pkg::PH_CK_A;
            end else begin
               phase_in = bgfd_pkg::PH_PAYLOAD;
            end
         end
         bgfd_pkg::PH_PAYLOAD: begin
            res.valid        = 1'b1;
            res.result_kind  = bgfd_pkg::KIND_PAYLOAD;
            res.payload_byte = rx_byte;
            res.byte_index   = count_ff;
            sum_a_in         = sum_a_add;
            sum_b_in         = sum_b_add;
            count_in         = count_inc;
            if ({6'd0, count_inc} >= length_ff) begin
               phase_in = bgfd_pkg::PH_CK_A;
            end
         end
         bgfd_pkg::PH_CK_A: begin
            if (rx_byte != sum_a_ff) begin
               phase_in        = bgfd_pkg::PH_HUNT;
               res.valid       = 1'b1;
               res.result_kind = bgfd_pkg::KIND_CKSUM;
            end else begin
               phase_in = bgfd_pkg::PH_CK_B;
            end
         end
         bgfd_pkg::PH_CK_B: begin
            phase_in  = bgfd_pkg::PH_HUNT;
            res.valid = 1'b1;
            if (rx_byte == sum_b_ff) begin
               res.result_kind  = bgfd_pkg::KIND_GOOD;
               res.message_type = bgfd_pkg::type_code(class_ff, id_ff);
            end else begin
               res.result_kind = bgfd_pkg::KIND_CKSUM;
            end
         end
         default: begin
            // hunting, also any unused phase code
            phase_in = (rx_byte == bgfd_pkg::SYNC_A) ? bgfd_pkg::PH_SYNC2 : bgfd_pkg::PH_HUNT;
         end
      endcase

      res.msg_class       = class_ff;
      res.msg_id          = id_ff;
      res.declared_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bgfd_pkg::PH_HUNT;
         class_ff  <= '0;
         id_ff     <= '0;
         length_ff <= '0;
         count_ff  <= '0;
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         class_ff  <= class_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
      end
   end

   // a reported frame end or error always returns to hunting
   a_end_hunts: assert property (@(posedge clock) disable iff (reset)
      (step && res.valid && res.result_kind != bgfd_pkg::KIND_PAYLOAD)
      |=> (phase_ff == bgfd_pkg::PH_HUNT))
      else $error("parser did not return to hunting after frame end");

   // payload index stays inside the declared length
   a_index_in_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bgfd_pkg::PH_PAYLOAD) |-> ({6'd0, count_ff} < length_ff))
      else $error("payload index beyond declared length");

   // payload phase only entered with an accepted nonzero length
   a_payload_len_ok: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bgfd_pkg::PH_PAYLOAD) |-> (length_ff != 16'd0 &&
      length_ff <= PAYLOAD_LIMIT))
      else $error("payload phase with bad length");

endmodule

@@ src/binary_gps_frame_deframer_unit.sv @@
// top level of the binary frame deframer: handshake, pipeline registers, limit register
// result path: an accepted byte passes the input register, then the result register;
//   bytes that end in no result give no beat
// throughput: one byte per cycle while the result side takes its beats; the parser
//   state update is a single phase decode plus 8-bit sum adds between the two registers
// reset: synchronous active-high, parser hunts for the first sync byte and
//   the length limit register returns to 1023
module binary_gps_frame_deframer_unit #(
   parameter logic [15:0] PAYLOAD_LIMIT = bgfd_pkg::PAYLOAD_LIMIT
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // [7:0] payload_byte, [17:8] byte_index,
                                     // [25:18] msg_class, [33:26] msg_id,
                                     // [49:34] declared_length,
                                     // [52:50] message_type, [55:53] zero
   output logic [1:0]  rsp_tuser,    // [1:0] result_kind
   // length limit register
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data   // [9:0] max_payload_len
);

   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   logic                      rsp_valid_ff;
   bgfd_pkg::bgfd_result_type rsp_ff;
   logic [9:0]                max_len_ff;

   logic                      advance;
   logic                      step;
   bgfd_pkg::bgfd_result_type res;

   // result register frees when empty or taken this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   // input register takes a beat when empty or moving on
   assign req_tready = !in_valid_ff || advance;
   // parser consumes the held byte when the result side can take its outcome
   assign step       = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   bgfd_parser #(
      .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .max_len (max_len_ff),
      .res     (res)
   );

   // result register, only bytes that produce a result raise valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step && res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= res;
      end
   end

   // limit register; the user must write it only while idle, the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= bgfd_pkg::MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.result_kind;
   assign rsp_tdata  = {3'd0,
                        rsp_ff.message_type,
                        rsp_ff.declared_length,
                        rsp_ff.msg_id,
                        rsp_ff.msg_class,
                        rsp_ff.byte_index,
                        rsp_ff.payload_byte};

   // a held byte is never dropped while the result side stalls
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held input byte lost during stall");

   // parser only steps when the result register can take its outcome
   a_step_room: assert property (@(posedge clock) disable iff (reset)
      step |-> (!rsp_valid_ff || rsp_tready))
      else $error("parser stepped into a full result register");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result changed");

endmodule

@@ tb/binary_gps_frame_deframer_unit_tb.sv @@
// self-checking testbench of the binary frame deframer: byte stream in, result beats checked
module binary_gps_frame_deframer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // how a generated frame is spoiled on purpose
   localparam int FLAW_NONE = 0;
   localparam int FLAW_CK_A = 1;
   localparam int FLAW_CK_B = 2;

   // receiver hold-off length and the run limit
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 300000;

   // one result beat, fields as the block reports them
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [9:0]  index;
      logic [7:0]  cls;
      logic [7:0]  id;
      logic [15:0] length;
      logic [2:0]  mtype;
   } deframe_beat_type;

   // frame parser model plus the queue of result beats still owed by the block
   class frame_checker;
      logic [3:0]       phase;
      logic [7:0]       cls;
      logic [7:0]       id;
      logic [15:0]      length;
      logic [9:0]       count;
      logic [7:0]       sum_a;
      logic [7:0]       sum_b;
      logic [9:0]       max_len;
      int               errors;
      deframe_beat_type due_beats[$];

      function new();
         phase   = bgfd_pkg::PH_HUNT;
         cls     = '0;
         id      = '0;
         length  = '0;
         count   = '0;
         sum_a   = '0;
         sum_b   = '0;
         max_len = bgfd_pkg::MAX_LEN_RESET;
         errors  = 0;
      endfunction

      function void set_limit(input logic [9:0] value);
         max_len = value;
      endfunction

      task report(input string what);
         $display("%0t mismatch: %s", $time, what);
         errors++;
      endtask

      function void fletcher_add(input logic [7:0] b);
         sum_a = sum_a + b;
         sum_b = sum_b + sum_a;
      endfunction

      // only class nav carries a known type
      function logic [2:0] nav_type();
         if (cls != bgfd_pkg::CLASS_NAV) return bgfd_pkg::MT_NONE;
         case (id)
            bgfd_pkg::ID_SOL:    return bgfd_pkg::MT_SOL;
            bgfd_pkg::ID_POSLLH: return bgfd_pkg::MT_POSLLH;
            bgfd_pkg::ID_VELNED: return bgfd_pkg::MT_VELNED;
            bgfd_pkg::ID_DOP:    return bgfd_pkg::MT_DOP;
            bgfd_pkg::ID_STATUS: return bgfd_pkg::MT_STATUS;
            default:             return bgfd_pkg::MT_NONE;
         endcase
      endfunction

      function deframe_beat_type make_beat(input logic [1:0] kind, input logic [7:0] data,
                                           input logic [9:0] index, input logic [2:0] mtype);
         deframe_beat_type beat;
         beat.kind   = kind;
         beat.data   = data;
         beat.index  = index;
         beat.cls    = cls;
         beat.id     = id;
         beat.length = length;
         beat.mtype  = mtype;
         return beat;
      endfunction

      // advance the parser by one accepted byte, queue the beat it causes
      function void track_rx_byte(input logic [7:0] b);
         logic [15:0] limit;
         limit = (bgfd_pkg::PAYLOAD_LIMIT < {6'd0, max_len}) ?
                 bgfd_pkg::PAYLOAD_LIMIT : {6'd0, max_len};
         case (phase)
            bgfd_pkg::PH_SYNC2: begin
               phase = (b == bgfd_pkg::SYNC_B) ? bgfd_pkg::PH_CLASS : bgfd_pkg::PH_HUNT;
            end
            bgfd_pkg::PH_CLASS: begin
               cls   = b;
               sum_a = '0;
               sum_b = '0;
               fletcher_add(b);
               phase = bgfd_pkg::PH_ID;
            end
            bgfd_pkg::PH_ID: begin
               id = b;
               fletcher_add(b);
               phase = bgfd_pkg::PH_LEN_LO;
            end
            bgfd_pkg::PH_LEN_LO: begin
               length = {8'd0, b};
               fletcher_add(b);
               phase = bgfd_pkg::PH_LEN_HI;
            end
            bgfd_pkg::PH_LEN_HI: begin
               length[15:8] = b;
               fletcher_add(b);
               count = '0;
               if (length > limit) begin
                  phase = bgfd_pkg::PH_HUNT;
                  due_beats.push_back(make_beat(bgfd_pkg::KIND_LENGTH, 8'd0, 10'd0,
                                                bgfd_pkg::MT_NONE));
               end else begin
                  phase = (length == 16'd0) ? bgfd_pkg::PH_CK_A : bgfd_pkg::PH_PAYLOAD;
               end
            end
            bgfd_pkg::PH_PAYLOAD: begin
               due_beats.push_back(make_beat(bgfd_pkg::KIND_PAYLOAD, b, count,
                                             bgfd_pkg::MT_NONE));
               fletcher_add(b);
               count = count + 10'd1;
               if ({6'd0, count} >= length) phase = bgfd_pkg::PH_CK_A;
            end
            bgfd_pkg::PH_CK_A: begin
               if (b != sum_a) begin
                  // ck_b is then scanned as an ordinary byte
                  phase = bgfd_pkg::PH_HUNT;
                  due_beats.push_back(make_beat(bgfd_pkg::KIND_CKSUM, 8'd0, 10'd0,
                                                bgfd_pkg::MT_NONE));
               end else begin
                  phase = bgfd_pkg::PH_CK_B;
               end
            end
            bgfd_pkg::PH_CK_B: begin
               phase = bgfd_pkg::PH_HUNT;
               if (b == sum_b)
                  due_beats.push_back(make_beat(bgfd_pkg::KIND_GOOD, 8'd0, 10'd0,
                                                nav_type()));
               else
                  due_beats.push_back(make_beat(bgfd_pkg::KIND_CKSUM, 8'd0, 10'd0,
                                                bgfd_pkg::MT_NONE));
            end
            // hunting, and any unused phase code
            default: begin
               phase = (b == bgfd_pkg::SYNC_A) ? bgfd_pkg::PH_SYNC2 : bgfd_pkg::PH_HUNT;
            end
         endcase
      endfunction

      // compare one accepted result beat with the oldest one owed
      task check_beat(input logic [1:0] kind, input logic [55:0] data);
         deframe_beat_type want;
         if (due_beats.size() == 0) begin
            report($sformatf("result beat with nothing owed, kind %0d", kind));
            return;
         end
         want = due_beats.pop_front();
         if (kind != want.kind)
            report($sformatf("result_kind %0d, want %0d", kind, want.kind));
         if (data[7:0] != want.data)
            report($sformatf("payload_byte %02h, want %02h", data[7:0], want.data));
         if (data[17:8] != want.index)
            report($sformatf("byte_index %0d, want %0d", data[17:8], want.index));
         if (data[25:18] != want.cls)
            report($sformatf("msg_class %02h, want %02h", data[25:18], want.cls));
         if (data[33:26] != want.id)
            report($sformatf("msg_id %02h, want %02h", data[33:26], want.id));
         if (data[49:34] != want.length)
            report($sformatf("declared_length %0d, want %0d", data[49:34], want.length));
         if (data[52:50] != want.mtype)
            report($sformatf("message_type %0d, want %0d", data[52:50], want.mtype));
         if (data[55:53] != 3'd0)
            report($sformatf("pad bits %b not zero", data[55:53]));
      endtask
   endclass

   // block ports, the ones driven here all known from time zero
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [55:0] rsp_tdata;            // [7:0] payload_byte, [17:8] byte_index,
                                      // [25:18] msg_class, [33:26] msg_id,
                                      // [49:34] declared_length, [52:50] message_type
   logic [1:0]  rsp_tuser;            // [1:0] result_kind
   logic        csr_wr_en   = 1'b0;
   logic [9:0]  csr_wr_data = 10'd0;  // [9:0] max_payload_len

   // idle odds in percent per beat, and the limit the generator assumes
   int          send_idle    = 0;
   int          recv_idle    = 0;
   logic [9:0]  cur_limit    = bgfd_pkg::MAX_LEN_RESET;
   int          bytes_sent   = 0;
   int          cycle_count  = 0;
   int          hold_left    = 0;
   logic        hold_request = 1'b0;

   frame_checker sb;

   binary_gps_frame_deframer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // monitors sample the values that stood before the edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.track_rx_byte(req_tdata);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(rsp_tuser, rsp_tdata);
   end

   // receiver: random stalls, or a long hold-off counted here when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("binary_gps_frame_deframer_unit test failed");
      $finish;
   end

   // offer one byte, idling first at random; valid stays high into the next call
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // sync, header, payload and checksum; header only when the length is over the limit
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] length, input int flaw);
      logic [7:0] hdr[4];
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      logic [7:0] pb;
      hdr  = '{cls, id, length[7:0], length[15:8]};
      ck_a = 8'd0;
      ck_b = 8'd0;
      send_byte(bgfd_pkg::SYNC_A);
      send_byte(bgfd_pkg::SYNC_B);
      foreach (hdr[i]) begin
         send_byte(hdr[i]);
         ck_a = ck_a + hdr[i];
         ck_b = ck_b + ck_a;
      end
      if (length > {6'd0, cur_limit}) return;
      for (int i = 0; i < length; i++) begin
         pb = 8'($urandom);
         send_byte(pb);
         ck_a = ck_a + pb;
         ck_b = ck_b + ck_a;
      end
      if (flaw == FLAW_CK_A) ck_a = ck_a ^ 8'($urandom_range(1, 255));
      if (flaw == FLAW_CK_B) ck_b = ck_b ^ 8'($urandom_range(1, 255));
      send_byte(ck_a);
      send_byte(ck_b);
   endtask

   // mostly well-formed frames with random content, the rest line noise and broken frames
   task automatic random_traffic(input int n);
      int          stop_at;
      int          pick;
      int          top;
      int          flaw;
      logic [7:0]  cls;
      logic [7:0]  id;
      logic [15:0] length;
      stop_at = bytes_sent + n;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            // noise, rich in first sync bytes so bad second syncs show up
            repeat ($urandom_range(1, 6))
               send_byte(($urandom_range(2) == 0) ? bgfd_pkg::SYNC_A : 8'($urandom));
         end else begin
            if ($urandom_range(1) == 0) begin
               cls = bgfd_pkg::CLASS_NAV;
               case ($urandom_range(5))
                  0:       id = bgfd_pkg::ID_SOL;
                  1:       id = bgfd_pkg::ID_POSLLH;
                  2:       id = bgfd_pkg::ID_VELNED;
                  3:       id = bgfd_pkg::ID_DOP;
                  4:       id = bgfd_pkg::ID_STATUS;
                  default: id = 8'($urandom);
               endcase
            end else begin
               cls = 8'($urandom);
               id  = 8'($urandom);
            end
            // lengths stay short; a few sit right at, just over or anywhere above the limit
            top  = (cur_limit < 10'd24) ? int'(cur_limit) : 24;
            pick = $urandom_range(99);
            if (pick < 5)
               length = 16'(cur_limit) + 16'd1;
            else if (pick < 10)
               length = 16'(cur_limit) + 16'($urandom_range(1, 65535 - int'(cur_limit)));
            else if (pick < 18 && cur_limit <= 10'd64)
               length = 16'(cur_limit);
            else
               length = 16'($urandom_range(0, top));
            pick = $urandom_range(99);
            flaw = (pick < 10) ? FLAW_CK_A : (pick < 20) ? FLAW_CK_B : FLAW_NONE;
            send_frame(cls, id, length, flaw);
         end
      end
   endtask

   // let every owed beat come back, then give in-flight bytes time to settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.due_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_limit(input logic [9:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_limit(value);
      cur_limit = value;
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // first pass: sender idles lightly, receiver stalls often; limit at its reset value
      send_idle = 22;
      recv_idle = 54;

      // noise at the byte extremes, a repeated first sync, a stray second sync
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(bgfd_pkg::SYNC_A);
      send_byte(bgfd_pkg::SYNC_A);
      send_byte(bgfd_pkg::SYNC_B);
      // empty nav solution frame
      send_frame(bgfd_pkg::CLASS_NAV, bgfd_pkg::ID_SOL, 16'd0, FLAW_NONE);
      // largest declared length, rejected at the high length byte
      send_frame(8'hA5, 8'h5A, 16'hFFFF, FLAW_NONE);
      // bad ck_b on an empty status frame
      send_frame(bgfd_pkg::CLASS_NAV, bgfd_pkg::ID_STATUS, 16'd0, FLAW_CK_B);

      random_traffic(100);

      // second pass: roles swapped; smallest limit, then a mid one
      drain();
      send_idle = 54;
      recv_idle = 22;
      write_limit(10'd0);
      random_traffic(100);

      drain();
      write_limit(10'd37);
      // long receiver hold-off while the sender keeps pushing a full-size frame
      hold_request = 1'b1;
      send_frame(bgfd_pkg::CLASS_NAV, bgfd_pkg::ID_POSLLH, 16'd37, FLAW_NONE);
      random_traffic(100);

      // third pass: no idling at all; largest limit with the longest frame and one just over it
      drain();
      send_idle = 0;
      recv_idle = 0;
      write_limit(10'd1023);
      send_frame(bgfd_pkg::CLASS_NAV, bgfd_pkg::ID_DOP, 16'd1023, FLAW_NONE);
      send_frame(bgfd_pkg::CLASS_NAV, bgfd_pkg::ID_VELNED, 16'd1024, FLAW_NONE);
      random_traffic(150);

      drain();
      write_limit(10'($urandom_range(1, 1022)));
      random_traffic(150);

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("binary_gps_frame_deframer_unit test passed");
      else
         $display("binary_gps_frame_deframer_unit test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
src/bgfd_pkg.sv
src/bgfd_parser.sv
src/binary_gps_frame_deframer_unit.sv
tb/binary_gps_frame_deframer_unit_tb.sv
